FILE: design/sds_pkg.sv
// Shared types and defaults for the saturating signed divider.
// Used by the controller, the datapath, the top level and the checker.
package sds_pkg;

  localparam int unsigned DataWidthDef = 32;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture operands, take magnitudes and signs
    logic step;    // one restoring shift-and-subtract iteration
    logic finish;  // apply sign and saturation, load the result register
  } sds_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic res_free;  // result register empty or being drained this cycle
  } sds_sts_t;

endpackage

FILE: design/signed_divider_saturating.sv
// Top level of the saturating signed divider.
// Instantiates sds_ctrl and sds_datapath; types come from sds_pkg.
//
// Usage:
//   Slave channel (s_axis_*) takes one dividend/divisor pair per transfer;
//   master channel (m_axis_*) gives one quotient per transfer, truncated
//   toward zero. A zero dividend gives 0, a zero divisor with a nonzero
//   dividend gives the most negative value, and the most negative value
//   divided by -1 saturates to the largest positive value.
// Timing:
//   Magnitudes and signs are captured at the input transfer itself; the
//   quotient reaches the output register after DATA_WIDTH iterations of the
//   single restoring subtract unit (one quotient bit per cycle) and the sign
//   fix-up, which waits until the output register is free.
//   s_axis_tready_o is high only while the unit is idle, so one item is in
//   flight at a time and no new item is taken until the last one has left
//   the sign fix-up; a new item is taken while a finished quotient still
//   waits in the output register.
// Reset: rst_ni clears the controller and the output valid; no item is kept.
// Stall: when m_axis_tready_i is low the quotient holds in the output
//   register, and a following item finishes its iterations, then waits until
//   the register drains.
module signed_divider_saturating #(
  parameter int unsigned DATA_WIDTH = sds_pkg::DataWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [DATA_WIDTH-1:0] numerator, [2*DATA_WIDTH-1:DATA_WIDTH] denominator,
  // zero padding above
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [DATA_WIDTH-1:0] quotient, zero padding above
  output logic [((DATA_WIDTH+7)/8)*8-1:0]   m_axis_tdata_o
);

  localparam int unsigned OutTdataW = ((DATA_WIDTH + 7) / 8) * 8;

  sds_pkg::sds_cmd_t     cmd;
  sds_pkg::sds_sts_t     sts;
  logic [DATA_WIDTH-1:0] quotient;

  sds_ctrl #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sds_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .numerator_i   (s_axis_tdata_i[DATA_WIDTH-1:0]),
    .denominator_i (s_axis_tdata_i[2*DATA_WIDTH-1:DATA_WIDTH]),
    .res_ready_i   (m_axis_tready_i),
    .res_valid_o   (m_axis_tvalid_o),
    .quotient_o    (quotient)
  );

  // zero-extend the quotient to whole bytes
  assign m_axis_tdata_o = OutTdataW'(quotient);

endmodule

FILE: design/sds_ctrl.sv
// Controller state machine for the saturating signed divider.
// Depends on sds_pkg for the command and status structs.
module sds_ctrl #(
  parameter int unsigned DATA_WIDTH = sds_pkg::DataWidthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sds_pkg::sds_sts_t sts_i,
  output sds_pkg::sds_cmd_t cmd_o
);

  localparam int unsigned CntW = $clog2(DATA_WIDTH);
  localparam logic [CntW-1:0] CntLast = CntW'(DATA_WIDTH - 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign in_ready_o    = (state_q == StIdle);
  assign cmd_o.load    = in_valid_i && in_ready_o;
  assign cmd_o.step    = (state_q == StRun);
  assign cmd_o.finish  = (state_q == StFin) && sts_i.res_free;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      StIdle: begin
        if (cmd_o.load) begin
          state_d = StRun;
          cnt_d   = '0;
        end
      end
      StRun: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntLast) begin
          state_d = StFin;
        end
      end
      StFin: begin
        // hold until the result register can take the quotient
        if (sts_i.res_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

FILE: design/sds_datapath.sv
// Datapath of the saturating signed divider: magnitudes, restoring iteration,
// sign fix-up with saturation and the output register. Depends on sds_pkg.
module sds_datapath #(
  parameter int unsigned DATA_WIDTH = sds_pkg::DataWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sds_pkg::sds_cmd_t     cmd_i,
  output sds_pkg::sds_sts_t     sts_o,
  input  logic [DATA_WIDTH-1:0] numerator_i,
  input  logic [DATA_WIDTH-1:0] denominator_i,
  input  logic                  res_ready_i,
  output logic                  res_valid_o,
  output logic [DATA_WIDTH-1:0] quotient_o
);

  localparam logic [DATA_WIDTH-1:0] MaxPos = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MinNeg = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // num_q shifts the dividend out at the top and the quotient in at the bottom
  logic [DATA_WIDTH-1:0] num_q, den_q, rem_q;
  logic                  nneg_q, dneg_q, nzero_q, dzero_q;
  logic                  res_valid_q;
  logic [DATA_WIDTH-1:0] res_q, res_d;

  logic [DATA_WIDTH-1:0] num_mag, den_mag, rem_sh, rem_sub;
  logic                  ge;

  assign num_mag = numerator_i[DATA_WIDTH-1]   ? (~numerator_i) + DATA_WIDTH'(1)
                                               : numerator_i;
  assign den_mag = denominator_i[DATA_WIDTH-1] ? (~denominator_i) + DATA_WIDTH'(1)
                                               : denominator_i;

  // Remainder stays below a nonzero divisor magnitude, so its top bit is then clear
  assign rem_sh  = {rem_q[DATA_WIDTH-2:0], num_q[DATA_WIDTH-1]};
  assign ge      = (rem_sh >= den_q);
  assign rem_sub = rem_sh - den_q;

  always_comb begin
    if (nzero_q) begin
      res_d = '0;
    end else if (dzero_q) begin
      res_d = MinNeg;
    end else if (nneg_q == dneg_q) begin
      res_d = num_q[DATA_WIDTH-1] ? MaxPos : num_q;
    end else begin
      res_d = (~num_q) + DATA_WIDTH'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      num_q   <= num_mag;
      den_q   <= den_mag;
      rem_q   <= '0;
      nneg_q  <= numerator_i[DATA_WIDTH-1];
      dneg_q  <= denominator_i[DATA_WIDTH-1];
      nzero_q <= (numerator_i == '0);
      dzero_q <= (denominator_i == '0);
    end else if (cmd_i.step) begin
      rem_q <= ge ? rem_sub : rem_sh;
      num_q <= {num_q[DATA_WIDTH-2:0], ge};
    end
    if (cmd_i.finish) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  assign sts_o.res_free = !res_valid_q || res_ready_i;
  assign res_valid_o    = res_valid_q;
  assign quotient_o     = res_q;

endmodule

FILE: design/sds_checker.sv
// Port-level checker for the saturating signed divider, bound to the top.
// Depends on sds_pkg for the default width.
module sds_checker #(
  parameter int unsigned DATA_WIDTH = sds_pkg::DataWidthDef
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic [((2*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [((DATA_WIDTH+7)/8)*8-1:0]   m_axis_tdata_o
);

  // hold a stalled result
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // ready stays low right after each input transfer
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o ##1 !s_axis_tready_o)
    else $error("input taken while a division is in flight");

  // a new result only appears after the unit was busy
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !$past(m_axis_tvalid_o && !m_axis_tready_i) |-> !$past(s_axis_tready_o))
    else $error("result without a division");

endmodule

bind signed_divider_saturating sds_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_sds_checker (.*);

FILE: tb/sv/signed_divider_saturating_tb.sv
// Self-checking bench for the saturating signed divider: directed corner cases
// first, then random operand pairs, with random stalls on both stream sides.
// Depends on sds_pkg and signed_divider_saturating.
module signed_divider_saturating_tb;

  localparam int DW    = sds_pkg::DataWidthDef;
  localparam int IN_W  = ((2 * DW + 7) / 8) * 8;
  localparam int OUT_W = ((DW + 7) / 8) * 8;

  localparam logic [DW-1:0] MOST_NEG  = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] MOST_POS  = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MINUS_ONE = {DW{1'b1}};
  localparam logic [DW-1:0] ONE       = {{(DW-1){1'b0}}, 1'b1};

  // One division in flight through the checker: operands kept for reports
  typedef struct {
    logic [DW-1:0] dividend;
    logic [DW-1:0] divisor;
    logic [DW-1:0] quotient;
  } division_t;

  // Tracks expected quotients in order and compares them with the output
  class quotient_scoreboard;
    division_t   awaited[$];
    int unsigned errors;
    int unsigned results;

    function new();
      errors  = 0;
      results = 0;
    endfunction

    // Truncating signed division, restoring shift-and-subtract on magnitudes
    function logic [DW-1:0] divide(logic [DW-1:0] dividend, logic [DW-1:0] divisor);
      logic [DW-1:0] mag_n;
      logic [DW-1:0] mag_d;
      logic [DW-1:0] quo;
      logic [DW:0]   rem;
      int            i;
      if (dividend == '0) return '0;
      // Zero divisor counts as neither sign, so the negative limit is picked
      if (divisor == '0) return MOST_NEG;
      mag_n = dividend[DW-1] ? -dividend : dividend;
      mag_d = divisor[DW-1] ? -divisor : divisor;
      rem   = '0;
      quo   = '0;
      for (i = DW - 1; i >= 0; i--) begin
        rem = {rem[DW-1:0], mag_n[i]};
        quo = quo << 1;
        if (rem >= {1'b0, mag_d}) begin
          rem    = rem - {1'b0, mag_d};
          quo[0] = 1'b1;
        end
      end
      if (dividend[DW-1] == divisor[DW-1]) begin
        // Only the most negative value over minus one lands above the range
        return (quo > MOST_POS) ? MOST_POS : quo;
      end
      return -quo;
    endfunction

    function void note_operands(logic [DW-1:0] dividend, logic [DW-1:0] divisor);
      division_t d;
      d.dividend = dividend;
      d.divisor  = divisor;
      d.quotient = divide(dividend, divisor);
      awaited.push_back(d);
    endfunction

    function void check_quotient(logic [DW-1:0] quotient);
      division_t d;
      results++;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected quotient %0d with nothing outstanding", $signed(quotient));
        return;
      end
      d = awaited.pop_front();
      if (quotient !== d.quotient) begin
        errors++;
        if (errors <= 10)
          $display("quotient mismatch: %0d / %0d expected %0d got %0d",
                   $signed(d.dividend), $signed(d.divisor),
                   $signed(d.quotient), $signed(quotient));
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              s_valid = 1'b0;
  logic [IN_W-1:0]   s_data  = '0;
  logic              s_ready;
  logic              m_valid;
  logic              m_ready = 1'b0;
  logic [OUT_W-1:0]  m_data;

  quotient_scoreboard board;
  int unsigned        sent        = 0;
  int unsigned        hold_left   = 0;
  bit                 hold_done   = 1'b0;

  signed_divider_saturating #(
    .DATA_WIDTH(DW)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),   // [DW-1:0] numerator, [2*DW-1:DW] denominator
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)    // [DW-1:0] quotient
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 0;
  end

  // Hard stop in case the block hangs
  initial begin
    #1000000;
    $display("*** FAILED ***");
    $finish;
  end

  // Offer one operand pair and hold it until the transfer completes.
  // Idle now and then, except in a calm stretch in the middle of the run.
  task automatic send_pair(input logic [DW-1:0] dividend, input logic [DW-1:0] divisor);
    logic [IN_W-1:0] word;
    word              = '0;
    word[DW-1:0]      = dividend;
    word[2*DW-1:DW]   = divisor;
    while (!(sent >= 400 && sent < 550) && $urandom_range(99) < 8) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= word;
    do @(posedge clk_i); while (!s_ready);
    board.note_operands(dividend, divisor);
    sent++;
  endtask

  // Pick an operand: mostly full range, the rest short magnitudes and limits
  function automatic logic [DW-1:0] pick_operand();
    logic [DW-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = $urandom;
      4, 5: begin
        v = $urandom >> $urandom_range(DW - 1);
        if ($urandom_range(1)) v = -v;
      end
      6: v = DW'($signed($urandom_range(16)) - 8);
      7: begin
        case ($urandom_range(4))
          0: v = MOST_NEG;
          1: v = MOST_POS;
          2: v = MINUS_ONE;
          3: v = ONE;
          default: v = MOST_NEG + 1;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Result side: check every output transfer, stall at random, and hold off
  // once for a long stretch so the block fills up and blocks its input
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_valid && m_ready) board.check_quotient(m_data[DW-1:0]);
      if (!hold_done && board.results == 120) begin
        hold_done = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else if (board.results >= 400 && board.results < 550) begin
        m_ready <= 1'b1;
      end else begin
        m_ready <= ($urandom_range(99) >= 8);
      end
    end
  end

  initial begin
    logic [DW-1:0] dividend;
    logic [DW-1:0] divisor;
    int            kind;
    board = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corner cases: zero dividend, zero divisor, overflow, limits, all signs
    send_pair('0, '0);
    send_pair('0, DW'(5));
    send_pair('0, MOST_NEG);
    send_pair(DW'(5), '0);
    send_pair(-DW'(5), '0);
    send_pair(MOST_NEG, '0);
    send_pair(MOST_POS, '0);
    send_pair(MOST_NEG, MINUS_ONE);
    send_pair(MOST_NEG, ONE);
    send_pair(MOST_NEG, MOST_NEG);
    send_pair(MOST_POS, MOST_POS);
    send_pair(MOST_POS, MINUS_ONE);
    send_pair(MOST_POS, MOST_NEG);
    send_pair(MOST_NEG, MOST_POS);
    send_pair(DW'(7), DW'(2));
    send_pair(-DW'(7), DW'(2));
    send_pair(DW'(7), -DW'(2));
    send_pair(-DW'(7), -DW'(2));
    send_pair(ONE, MOST_POS);
    send_pair(MINUS_ONE, MOST_NEG);
    send_pair(DW'(3), DW'(7));
    send_pair(MINUS_ONE, MINUS_ONE);
    send_pair(MOST_POS, ONE);

    // Random pairs, with the special cases forced now and then
    repeat (850) begin
      dividend = pick_operand();
      divisor  = pick_operand();
      kind     = $urandom_range(99);
      if (kind < 3) dividend = '0;
      else if (kind < 6) divisor = '0;
      else if (kind < 7) begin
        dividend = MOST_NEG;
        divisor  = MINUS_ONE;
      end else if (kind < 30) begin
        // Shrink the divisor so quotients grow wide
        divisor = $signed(divisor) >>> $urandom_range(DW - 1);
      end
      send_pair(dividend, divisor);
    end
    s_valid <= 1'b0;

    // Drain, then leave room for any stray output
    while (board.pending() != 0) @(posedge clk_i);
    repeat (2 * DW + 8) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
